>>> rtl/y4mle_pkg.sv
// Shared request and response types for the Y4M luma extractor.
`default_nettype none

package y4mle_pkg;

   // Width of the row, column and dimension fields on the response
   localparam int FIELD_W = 12;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       stream_start;
   } req_type;

   typedef struct packed {
      logic [7:0]         pixel;
      logic [FIELD_W-1:0] row;
      logic [FIELD_W-1:0] col;
      logic               frame_last;
      logic [FIELD_W-1:0] frame_width;
      logic [FIELD_W-1:0] frame_height;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/y4m_luma_extractor_top.sv
// Y4M 4:2:0 luma extractor: input register, stream parser, response register.
//
// Usage: raw stream bytes enter on the req_ channel (req_valid/req_ready,
// payload req_data with data_byte and stream_start). stream_start on a byte
// restarts header parsing with that byte as the first of a new stream.
// Each luma byte of every frame leaves on the rsp_ channel (rsp_valid/
// rsp_ready, payload rsp_data) tagged with row, column, frame_last and the
// parsed frame size; header, chroma and frame-header bytes give no response.
// A luma request is captured in the input register, and the parser step
// writes its response into the response register. Throughput: one request
// per cycle, set by the combinational parser step between the registers.
// When the receiver stalls, the response register holds, the input
// register takes one more request, and then req_ready drops until
// rsp_ready returns. Reset (synchronous) empties both registers and
// returns the parser to header scan with zero width and height.
`default_nettype none

module y4m_luma_extractor_top import y4mle_pkg::*; #(
   parameter int MAX_DIM = 4095
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   req_type in_ff;
   logic    in_valid_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   rsp_type step_rsp;
   logic    step_emit;
   logic    out_free;
   logic    step_en;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign step_en   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_ff <= req_data;
      end
   end

   y4mle_parser #(
      .MAX_DIM (MAX_DIM)
   ) u_parser (
      .clock    (clock),
      .reset    (reset),
      .step_en  (step_en),
      .req      (in_ff),
      .rsp      (step_rsp),
      .rsp_emit (step_emit)
   );

   // Response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_free) begin
         rsp_valid_ff <= step_en && step_emit;
      end
   end

   always_ff @(posedge clock) begin
      if (step_en && step_emit) begin
         rsp_ff <= step_rsp;
      end
   end

`ifndef NO_ASSERTIONS
   // A held request stays put while the response side is blocked
   a_in_hold: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_free) |=> (in_valid_ff && $stable(in_ff)))
      else $error("input register changed while blocked");

   // req_ready only drops with both registers full
   a_ready_low: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (in_valid_ff && rsp_valid_ff))
      else $error("req_ready low with free space");

   // The last sample of a frame sits in the last column
   a_last_col: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.frame_last) |->
         ((rsp_ff.col + 12'd1) == rsp_ff.frame_width))
      else $error("frame_last off the last column");
`endif

endmodule

`default_nettype wire

>>> rtl/y4mle_parser.sv
// Stream parser: header scan, frame sequencing and luma sample tagging.
`default_nettype none

module y4mle_parser import y4mle_pkg::*; #(
   parameter int MAX_DIM = 4095
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    step_en,
   input  wire req_type req,
   output rsp_type      rsp,
   output logic         rsp_emit
);

   localparam int DIM_W = $clog2(MAX_DIM + 1);
   localparam int ACC_W = DIM_W + 4;
   localparam int CHR_W = 2 * DIM_W;

   // Phase codes
   localparam logic [2:0] PH_HDR     = 3'd0;
   localparam logic [2:0] PH_NUM_W   = 3'd1;
   localparam logic [2:0] PH_NUM_H   = 3'd2;
   localparam logic [2:0] PH_DROP1   = 3'd3;
   localparam logic [2:0] PH_HDRLINE = 3'd4;
   localparam logic [2:0] PH_LUMA    = 3'd5;
   localparam logic [2:0] PH_CHROMA  = 3'd6;
   localparam logic [2:0] PH_FRMLINE = 3'd7;

   // Byte codes
   localparam logic [7:0] CH_NL   = 8'h0A;
   localparam logic [7:0] CH_W    = 8'h57;
   localparam logic [7:0] CH_H    = 8'h48;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;

   localparam logic [ACC_W-1:0] TEN     = ACC_W'(10);
   localparam logic [ACC_W-1:0] SAT_MAX = ACC_W'(MAX_DIM);
   localparam logic [DIM_W-1:0] DIM_ONE = DIM_W'(1);

   logic [2:0]       phase_ff, phase_in;
   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] row_ff, row_in;
   logic [DIM_W-1:0] col_ff, col_in;
   logic [CHR_W-1:0] chroma_ff, chroma_in;
   logic [CHR_W-1:0] chroma_total_ff;
   logic [CHR_W-1:0] chroma_total_in;

   // Start of stream overrides the stored state
   logic [2:0]       cur_phase;
   logic [DIM_W-1:0] cur_w, cur_h, cur_row, cur_col;
   logic [CHR_W-1:0] cur_chroma;

   logic             is_digit;
   logic [ACC_W-1:0] acc_src;
   logic [ACC_W-1:0] acc;
   logic [DIM_W-1:0] acc_sat;
   logic             last_col, last_row;
   logic [CHR_W-1:0] chroma_dec;
   logic             chroma_none;

   assign cur_phase  = req.stream_start ? PH_HDR : phase_ff;
   assign cur_w      = req.stream_start ? '0 : width_ff;
   assign cur_h      = req.stream_start ? '0 : height_ff;
   assign cur_row    = req.stream_start ? '0 : row_ff;
   assign cur_col    = req.stream_start ? '0 : col_ff;
   assign cur_chroma = req.stream_start ? '0 : chroma_ff;

   // Decimal accumulate with saturation
   assign is_digit = (req.data_byte >= CH_ZERO) && (req.data_byte <= CH_NINE);
   assign acc_src  = (cur_phase == PH_NUM_W) ? ACC_W'(cur_w) : ACC_W'(cur_h);
   assign acc      = acc_src * TEN + ACC_W'(req.data_byte[3:0]);
   assign acc_sat  = (acc > SAT_MAX) ? DIM_W'(MAX_DIM) : acc[DIM_W-1:0];

   // Raster position checks
   assign last_col = ({1'b0, cur_col} + {1'b0, DIM_ONE}) >= {1'b0, cur_w};
   assign last_row = ({1'b0, cur_row} + {1'b0, DIM_ONE}) >= {1'b0, cur_h};

   // Chroma byte count per frame, refreshed from the dimension registers
   assign chroma_total_in = CHR_W'(width_ff[DIM_W-1:1] * height_ff[DIM_W-1:1]) << 1;
   assign chroma_none     = (chroma_total_ff == '0);
   assign chroma_dec      = cur_chroma - CHR_W'(cur_chroma != '0);

   // Next state and response
   always_comb begin
      phase_in  = cur_phase;
      width_in  = cur_w;
      height_in = cur_h;
      row_in    = cur_row;
      col_in    = cur_col;
      chroma_in = cur_chroma;
      rsp_emit  = 1'b0;

      rsp.pixel        = req.data_byte;
      rsp.row          = FIELD_W'(cur_row);
      rsp.col          = FIELD_W'(cur_col);
      rsp.frame_last   = last_col && last_row;
      rsp.frame_width  = FIELD_W'(cur_w);
      rsp.frame_height = FIELD_W'(cur_h);

      unique case (cur_phase)
         PH_HDR, PH_NUM_W, PH_NUM_H: begin
            if ((cur_phase == PH_NUM_W) && is_digit) begin
               width_in = acc_sat;
            end else if ((cur_phase == PH_NUM_H) && is_digit) begin
               height_in = acc_sat;
            end else begin
               // Header byte scan, also for the byte that ends a number
               phase_in = PH_HDR;
               if (req.data_byte == CH_NL) begin
                  phase_in = PH_DROP1;
               end else if (req.data_byte == CH_W) begin
                  width_in = '0;
                  phase_in = PH_NUM_W;
               end else if (req.data_byte == CH_H) begin
                  height_in = '0;
                  phase_in = PH_NUM_H;
               end
            end
         end
         PH_DROP1: begin
            phase_in = PH_HDRLINE;
         end
         PH_HDRLINE, PH_FRMLINE: begin
            if (req.data_byte == CH_NL) begin
               row_in = '0;
               col_in = '0;
               if ((cur_w == '0) || (cur_h == '0)) begin
                  chroma_in = chroma_total_ff;
                  phase_in  = chroma_none ? PH_FRMLINE : PH_CHROMA;
               end else begin
                  phase_in = PH_LUMA;
               end
            end
         end
         PH_CHROMA: begin
            chroma_in = chroma_dec;
            if (chroma_dec == '0) begin
               phase_in = PH_FRMLINE;
            end
         end
         PH_LUMA: begin
            rsp_emit = 1'b1;
            if (last_col) begin
               col_in = '0;
               if (last_row) begin
                  row_in    = '0;
                  chroma_in = chroma_total_ff;
                  phase_in  = chroma_none ? PH_FRMLINE : PH_CHROMA;
               end else begin
                  row_in = cur_row + DIM_ONE;
               end
            end else begin
               col_in = cur_col + DIM_ONE;
            end
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR;
         width_ff        <= '0;
         height_ff       <= '0;
         row_ff          <= '0;
         col_ff          <= '0;
         chroma_ff       <= '0;
         chroma_total_ff <= '0;
      end else begin
         chroma_total_ff <= chroma_total_in;
         if (step_en) begin
            phase_ff  <= phase_in;
            width_ff  <= width_in;
            height_ff <= height_in;
            row_ff    <= row_in;
            col_ff    <= col_in;
            chroma_ff <= chroma_in;
         end
      end
   end

endmodule

`default_nettype wire

>>> dv/y4m_luma_checker.sv
// Scoreboard for the Y4M luma extractor: predicts every pixel response and checks it.
module y4m_luma_checker import y4mle_pkg::*; #(
   parameter int MAX_DIM = 4095
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   input  wire logic    req_ready,
   input  wire req_type req_data,
   input  wire logic    rsp_valid,
   input  wire logic    rsp_ready,
   input  wire rsp_type rsp_data,
   output int           fail_count,
   output int           pending,
   output int           pixels_checked,
   output int           frames_checked
);

   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam logic [7:0] TAG_WIDTH  = "W";
   localparam logic [7:0] TAG_HEIGHT = "H";
   localparam logic [7:0] DIGIT_ZERO = "0";
   localparam logic [7:0] DIGIT_NINE = "9";

   typedef enum logic [2:0] {
      SCAN_HDR,
      SCAN_WIDTH,
      SCAN_HEIGHT,
      DROP_ONE,
      SKIP_HDR_LINE,
      LUMA,
      CHROMA,
      SKIP_FRAME_LINE
   } parse_phase_type;

   // Parser state mirrored from the stream
   parse_phase_type phase;
   int           width_px;
   int           height_px;
   int           row_idx;
   int           col_idx;
   int           chroma_left;

   // Pixels predicted but not yet seen on the response side
   rsp_type      pixel_queue[$];

   task automatic restart_parse();
      phase       = SCAN_HDR;
      width_px    = 0;
      height_px   = 0;
      row_idx     = 0;
      col_idx     = 0;
      chroma_left = 0;
   endtask

   function automatic int add_digit(input int value, input int digit);
      int grown;
      grown = value * 10 + digit;
      return (grown > MAX_DIM) ? MAX_DIM : grown;
   endfunction

   task automatic scan_header_byte(input logic [7:0] b);
      if (b == NEWLINE) begin
         phase = DROP_ONE;
      end else if (b == TAG_WIDTH) begin
         width_px = 0;
         phase    = SCAN_WIDTH;
      end else if (b == TAG_HEIGHT) begin
         height_px = 0;
         phase     = SCAN_HEIGHT;
      end
   endtask

   // Two chroma planes of quarter size; none at all for a width or height below two
   task automatic start_chroma();
      chroma_left = (width_px / 2) * (height_px / 2) * 2;
      phase       = (chroma_left == 0) ? SKIP_FRAME_LINE : CHROMA;
   endtask

   task automatic start_frame();
      row_idx = 0;
      col_idx = 0;
      if (width_px == 0 || height_px == 0) start_chroma();
      else phase = LUMA;
   endtask

   // One stream byte in; at most one pixel out
   task automatic parse_byte(input req_type item, output bit emits, output rsp_type pix);
      logic [7:0] b;
      bit         last_col;
      bit         last_row;
      b     = item.data_byte;
      emits = 1'b0;
      pix   = '0;
      if (item.stream_start) restart_parse();
      case (phase)
         SCAN_HDR: scan_header_byte(b);
         SCAN_WIDTH, SCAN_HEIGHT: begin
            if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
               if (phase == SCAN_WIDTH) width_px = add_digit(width_px, b - DIGIT_ZERO);
               else height_px = add_digit(height_px, b - DIGIT_ZERO);
            end else begin
               // the byte that ends a number is a header byte in its own right
               phase = SCAN_HDR;
               scan_header_byte(b);
            end
         end
         DROP_ONE: phase = SKIP_HDR_LINE;
         SKIP_HDR_LINE, SKIP_FRAME_LINE: begin
            if (b == NEWLINE) start_frame();
         end
         CHROMA: begin
            if (chroma_left > 0) chroma_left--;
            if (chroma_left == 0) phase = SKIP_FRAME_LINE;
         end
         LUMA: begin
            last_col           = (col_idx + 1 >= width_px);
            last_row           = (row_idx + 1 >= height_px);
            emits              = 1'b1;
            pix.pixel          = b;
            pix.row            = row_idx[FIELD_W-1:0];
            pix.col            = col_idx[FIELD_W-1:0];
            pix.frame_last     = last_col && last_row;
            pix.frame_width    = width_px[FIELD_W-1:0];
            pix.frame_height   = height_px[FIELD_W-1:0];
            if (last_col) begin
               col_idx = 0;
               if (last_row) begin
                  row_idx = 0;
                  start_chroma();
               end else begin
                  row_idx++;
               end
            end else begin
               col_idx++;
            end
         end
         default: ;
      endcase
   endtask

   task automatic note_mismatch(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("MISMATCH: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [FIELD_W-1:0] want_v,
                              input logic [FIELD_W-1:0] got_v);
      if (got_v !== want_v)
         note_mismatch($sformatf("pixel %0d: %s expected 0x%0h, got 0x%0h",
                                 pixels_checked, name, want_v, got_v));
   endtask

   // Responses are matched before the request of the same edge is predicted,
   // since a pixel can never leave in the cycle its byte enters
   always @(posedge clock) begin : watch
      rsp_type want;
      bit      emits;
      if (reset) begin
         restart_parse();
         pixel_queue.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            pixels_checked++;
            if (pixel_queue.size() == 0) begin
               note_mismatch($sformatf("pixel %0d arrived with none predicted: %p",
                                       pixels_checked, rsp_data));
            end else begin
               want = pixel_queue.pop_front();
               if (want.frame_last) frames_checked++;
               check_field("pixel", want.pixel, rsp_data.pixel);
               check_field("row", want.row, rsp_data.row);
               check_field("col", want.col, rsp_data.col);
               check_field("frame_last", want.frame_last, rsp_data.frame_last);
               check_field("frame_width", want.frame_width, rsp_data.frame_width);
               check_field("frame_height", want.frame_height, rsp_data.frame_height);
            end
         end
         if (req_valid && req_ready) begin
            parse_byte(req_data, emits, want);
            if (emits) pixel_queue.insert(pixel_queue.size(), want);
         end
      end
      pending <= pixel_queue.size();
   end

endmodule

>>> dv/tb_y4m_luma_extractor_top.sv
// Testbench top for the Y4M luma extractor: clock, reset, byte streams and verdict.
module tb_y4m_luma_extractor_top;
   import y4mle_pkg::*;

   localparam int DIM_LIMIT     = 4095;
   localparam int ITEM_TARGET   = 900;
   localparam int HOLD_CYCLES   = 100;
   localparam int STALL_LIMIT   = 3000;
   localparam int NO_DIGITS     = -1;
   localparam int SPACED_DIGITS = -2;
   localparam logic [7:0] NEWLINE    = 8'h0A;
   localparam logic [7:0] TAG_WIDTH  = "W";
   localparam logic [7:0] TAG_HEIGHT = "H";

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   int fail_count;
   int pending;
   int pixels_checked;
   int frames_checked;
   int items_sent   = 0;
   int streams_sent = 0;
   int idle_cycles  = 0;
   int src_busy     = 0;
   int sink_busy    = 0;
   bit quiet        = 1'b0;
   bit long_hold    = 1'b0;

   always #6 clock = ~clock;

   y4m_luma_extractor_top #(.MAX_DIM(DIM_LIMIT)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   y4m_luma_checker #(.MAX_DIM(DIM_LIMIT)) scoreboard (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .pixels_checked (pixels_checked),
      .frames_checked (frames_checked)
   );

   // Watchdog: nothing moving on either channel for too long ends the run
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no request or pixel moved for %0d cycles", idle_cycles);
         $display("Verification failed");
         $finish;
      end
   end

   // Pixel sink: random stall bursts, plus one long hold-off on request
   initial begin : sink
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 15) < sink_busy * 3) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
      end
   end

   // One request; valid stays up into the next request unless a gap follows
   task automatic send_byte(input logic [7:0] b, input logic start);
      req_data  <= '{data_byte: b, stream_start: start};
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      if (!quiet && $urandom_range(0, 15) < src_busy * 3) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // n arbitrary bytes other than newline, then the newline
   task automatic send_line(input int n);
      logic [7:0] b;
      repeat (n) begin
         b = $urandom_range(0, 255);
         send_byte((b == NEWLINE) ? 8'h20 : b, 1'b0);
      end
      send_byte(NEWLINE, 1'b0);
   endtask

   // Header token: blank, tag, then digits (maybe zero padded) or a degenerate form
   task automatic send_dim(input logic [7:0] tag, input int value);
      send_text(" ");
      send_byte(tag, 1'b0);
      if (value == NO_DIGITS) return;
      if (value == SPACED_DIGITS) begin
         send_text(" 42");
         return;
      end
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) send_text("0");
      send_text($sformatf("%0d", value));
   endtask

   // Hold off new bytes until every predicted pixel has come out
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // One stream: header, dropped byte, header line, then frames of luma, chroma
   // and a frame line; some streams are noise, degenerate or cut short
   task automatic run_stream(input bit hold_luma);
      int kind;
      int w;
      int h;
      int w_text;
      int h_text;
      int frames;
      int n;
      bit partial;
      streams_sent++;
      kind = hold_luma ? 0 : $urandom_range(0, 9);
      if (kind == 9) begin
         // noise: any bytes at all, may wander into any parser state
         send_byte($urandom_range(0, 255), 1'b1);
         repeat ($urandom_range(4, 40)) send_byte($urandom_range(0, 255), 1'b0);
         return;
      end
      w = $urandom_range(1, 10);
      h = $urandom_range(1, 8);
      case ($urandom_range(0, 9))
         0: w = 1;
         1: h = 1;
         2: begin
            w = $urandom_range(11, 16);
            h = $urandom_range(6, 8);
         end
         default: ;
      endcase
      if (hold_luma) begin
         w = 10;
         h = 8;
      end
      w_text  = w;
      h_text  = h;
      partial = 1'b0;
      if (kind == 7) begin
         // saturating size; the frame is far too big, so it is cut short
         partial = 1'b1;
         if ($urandom_range(0, 1)) begin
            w_text = $urandom_range(DIM_LIMIT, 99999);
            w      = DIM_LIMIT;
         end else begin
            h_text = $urandom_range(DIM_LIMIT, 99999);
            h      = DIM_LIMIT;
         end
      end else if (kind == 8) begin
         // zero, missing or blank-separated digits all leave a zero dimension
         n = ($urandom_range(0, 2) == 0) ? 0 :
             ($urandom_range(0, 1) ? NO_DIGITS : SPACED_DIGITS);
         if ($urandom_range(0, 1)) begin
            w_text = n;
            w      = 0;
         end else begin
            h_text = n;
            h      = 0;
         end
      end

      send_byte("Y", 1'b1);
      send_text("UV4MPEG2");
      if (kind == 6) begin
         // stale tags, overridden by the ones that follow
         send_dim(TAG_WIDTH, $urandom_range(0, 9999));
         send_dim(TAG_HEIGHT, $urandom_range(0, 9999));
      end
      if ($urandom_range(0, 1)) begin
         send_dim(TAG_WIDTH, w_text);
         send_dim(TAG_HEIGHT, h_text);
      end else begin
         send_dim(TAG_HEIGHT, h_text);
         send_dim(TAG_WIDTH, w_text);
      end
      case ($urandom_range(0, 4))
         0: send_text(" F30:1 Ip");
         1: send_text(" A1:1");
         2: send_text(" C420jpeg XYSCSS=420JPEG");
         default: ;
      endcase
      send_byte(NEWLINE, 1'b0);
      send_byte($urandom_range(0, 255), 1'b0);
      send_line($urandom_range(0, 6));

      frames = $urandom_range(1, 3);
      if (w == 0 || h == 0) begin
         // every line is an empty frame
         repeat (frames) send_line($urandom_range(0, 8));
         return;
      end
      repeat (frames) begin
         n = partial ? $urandom_range(10, 50) : w * h;
         if (!partial && $urandom_range(0, 11) == 0) begin
            n       = $urandom_range(0, w * h - 1);
            partial = 1'b1;
         end
         if (hold_luma) begin
            long_hold = 1'b1;
            hold_luma = 1'b0;
         end
         repeat (n) send_byte($urandom_range(0, 255), 1'b0);
         if (partial) return;
         repeat ((w / 2) * (h / 2) * 2) send_byte($urandom_range(0, 255), 1'b0);
         send_text("FRAME");
         send_line($urandom_range(0, 4));
      end
   endtask

   initial begin : stimulus
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // width one, height two: extreme pixel values, no chroma after the plane
      send_byte(TAG_WIDTH, 1'b1);
      send_text("1H2");
      send_byte(NEWLINE, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte(8'hFF, 1'b0);
      send_byte(8'h00, 1'b0);

      // blank before the width digits and a zero height: empty frames per line,
      // and the dropped byte is itself a newline
      send_byte(TAG_WIDTH, 1'b1);
      send_text(" 7H0");
      repeat (4) send_byte(NEWLINE, 1'b0);

      // repeated height tag, the last one saturating; luma bytes that look like markup
      send_byte(TAG_HEIGHT, 1'b1);
      send_text("9W1H70000");
      send_byte(NEWLINE, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte(NEWLINE, 1'b0);
      send_byte(TAG_WIDTH, 1'b0);

      // random streams; one carries the long sink hold-off, some start after a drain
      while (items_sent < ITEM_TARGET) begin
         quiet     = (items_sent > ITEM_TARGET * 4 / 5);
         src_busy  = $urandom_range(0, 3);
         sink_busy = $urandom_range(0, 3);
         if (streams_sent % 5 == 4) drain_results();
         if (streams_sent == 1) src_busy = 0;
         run_stream(streams_sent == 1);
      end

      drain_results();
      repeat (4) @(posedge clock);
      $display("Run: %0d stream bytes over %0d random streams plus directed header cases",
               items_sent, streams_sent);
      $display("Run: %0d luma pixels checked, %0d completed frames", pixels_checked,
               frames_checked);
      if (fail_count == 0 && pending == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
